// File: rtl/core/bfdc_pkg.sv
// shared types and constants of the bt656 field deinterleave capture block
`default_nettype none

package bfdc_pkg;

    // field widths
    localparam int DATA_W  = 8;
    localparam int LPF_W   = 11;
    localparam int FBB_W   = 21;
    localparam int KIND_W  = 2;
    localparam int SEQ_W   = 32;

    // sync preamble bytes
    localparam logic [DATA_W-1:0] SYNC_FF = 8'hFF;
    localparam logic [DATA_W-1:0] SYNC_00 = 8'h00;

    // timing code bit positions
    localparam int TRC_EAV_BIT   = 4;
    localparam int TRC_BLANK_BIT = 5;
    localparam int TRC_FIELD_BIT = 6;

    // sync hunt phases
    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_GOT_FF = 2'd1;
    localparam logic [1:0] PH_GOT_00 = 2'd2;
    localparam logic [1:0] PH_TRC    = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHORT    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLAIM    = 2'd3;

    // configuration register indexes
    localparam logic CFG_LINES_PER_FRAME    = 1'b0;
    localparam logic CFG_FRAME_BUFFER_BYTES = 1'b1;

    localparam logic [LPF_W-1:0] LPF_RESET = 11'd480;
    localparam logic [FBB_W-1:0] FBB_RESET = 21'd691200;

    // active line count saturates here
    localparam logic [LPF_W-1:0] LINE_COUNT_MAX = 11'd2047;

    // op queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    // one classified op: a timing code, or one to three video bytes
    // (two and three mean a broken preamble replayed ahead of data)
    typedef struct packed {
        logic              is_trc;
        logic [1:0]        nvid;
        logic [DATA_W-1:0] data;
        logic              free_buf;
    } t_op;

    // one result without its last flag
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FBB_W-1:0]  write_address;
        logic [DATA_W-1:0] pixel_value;
        logic [FBB_W-1:0]  payload_bytes;
        logic [SEQ_W-1:0]  frame_sequence;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/bfdc_front.sv
// front end: preamble hunt and classification of stream bytes into ops
`default_nettype none

module bfdc_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [bfdc_pkg::DATA_W-1:0] i_data_byte,
    input  wire logic                      i_free_buffer,
    input  wire logic                      i_queue_full,
    output logic                           o_push,
    output bfdc_pkg::t_op                  o_op
);

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic       accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // classify the byte against the hunt phase
    always_comb begin
        n_phase         = r_phase;
        o_push          = 1'b0;
        o_op.is_trc     = 1'b0;
        o_op.nvid       = 2'd1;
        o_op.data       = i_data_byte;
        o_op.free_buf   = i_free_buffer;
        if (accept) begin
            unique case (r_phase)
                bfdc_pkg::PH_HUNT: begin
                    if (i_data_byte == bfdc_pkg::SYNC_FF) begin
                        n_phase = bfdc_pkg::PH_GOT_FF;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                bfdc_pkg::PH_GOT_FF: begin
                    if (i_data_byte == bfdc_pkg::SYNC_00) begin
                        n_phase = bfdc_pkg::PH_GOT_00;
                    end else begin
                        n_phase   = bfdc_pkg::PH_HUNT;
                        o_push    = 1'b1;
                        o_op.nvid = 2'd2;
                    end
                end
                bfdc_pkg::PH_GOT_00: begin
                    if (i_data_byte == bfdc_pkg::SYNC_00) begin
                        n_phase = bfdc_pkg::PH_TRC;
                    end else begin
                        n_phase   = bfdc_pkg::PH_HUNT;
                        o_push    = 1'b1;
                        o_op.nvid = 2'd3;
                    end
                end
                default: begin
                    n_phase     = bfdc_pkg::PH_HUNT;
                    o_push      = 1'b1;
                    o_op.is_trc = 1'b1;
                end
            endcase
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bfdc_pkg::PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bfdc_queue.sv
// short op queue that decouples the front end from the executor
`default_nettype none

module bfdc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  bfdc_pkg::t_op      i_op,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output bfdc_pkg::t_op      o_op
);

    bfdc_pkg::t_op                 r_mem [bfdc_pkg::QUEUE_DEPTH];
    logic [bfdc_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [bfdc_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [bfdc_pkg::QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == bfdc_pkg::QCNT_W'(bfdc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bfdc_back.sv
// executor: frame state, interleaved addressing and result ordering
`default_nettype none

module bfdc_back #(
    parameter int BYTES_PER_LINE = 1440
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [bfdc_pkg::LPF_W-1:0]    i_lines_per_frame,
    input  wire logic [bfdc_pkg::FBB_W-1:0]    i_frame_buffer_bytes,
    input  wire logic                          i_head_valid,
    input  bfdc_pkg::t_op                      i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bfdc_pkg::t_result                  o_result,
    output logic                               o_last
);

    localparam int COL_W  = $clog2(BYTES_PER_LINE);
    localparam int LINE_W = $clog2(((1 << bfdc_pkg::FBB_W) - 1) / BYTES_PER_LINE + 1);
    localparam int CMP_W  = (LINE_W > bfdc_pkg::LPF_W) ? LINE_W : bfdc_pkg::LPF_W;
    localparam int ADR_N  = $clog2(2 * BYTES_PER_LINE * 2048);
    localparam int ADR_W  = (ADR_N > bfdc_pkg::FBB_W) ? ADR_N : bfdc_pkg::FBB_W;
    localparam int NEED_N = $clog2(BYTES_PER_LINE * 2048);
    localparam int NEED_W = (NEED_N > bfdc_pkg::FBB_W) ? NEED_N : bfdc_pkg::FBB_W;

    // frame state
    logic                          r_buf_active, n_buf_active;
    logic                          r_blanking,   n_blanking;
    logic                          r_second,     n_second;
    logic [bfdc_pkg::LPF_W-1:0]    r_alc,        n_alc;
    logic [bfdc_pkg::FBB_W-1:0]    r_wp,         n_wp;
    logic [COL_W-1:0]              r_col,        n_col;
    logic [LINE_W-1:0]             r_line,       n_line;
    logic [bfdc_pkg::SEQ_W-1:0]    r_seq,        n_seq;
    logic [1:0]                    r_sub,        n_sub;

    // result ordering
    logic                          r_hold_valid, n_hold_valid;
    bfdc_pkg::t_result             r_hold,       n_hold;
    logic                          r_flush,      n_flush;
    logic                          r_out_valid;
    bfdc_pkg::t_result             r_out;
    logic                          r_out_last;

    logic                          slot_free;
    logic                          step_valid;
    logic                          step_emit;
    logic                          step_final;
    bfdc_pkg::t_result             step_res;
    logic                          push;
    logic                          push_last;
    bfdc_pkg::t_result             push_res;

    logic [bfdc_pkg::DATA_W-1:0]   cur_byte;
    logic                          vid_final;
    logic [bfdc_pkg::LPF_W-1:0]    alc_m1;
    logic [CMP_W-1:0]              line_ext;
    logic [CMP_W-1:0]              half_ext;
    logic [CMP_W-1:0]              line_in_field;
    logic                          line_match;
    logic [ADR_W-1:0]              addr;
    logic                          addr_ok;
    logic                          below_cap;
    logic [NEED_W-1:0]             need;
    logic                          is_short;
    bfdc_pkg::t_result             fin_res;
    bfdc_pkg::t_result             pix_res;
    bfdc_pkg::t_result             claim_res;
    logic                          trc_sav;
    logic                          trc_act;
    logic                          trc_f2;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign step_valid = slot_free && !r_flush && i_head_valid;

    // byte of the current replay position
    always_comb begin
        cur_byte = i_head.data;
        priority if (i_head.nvid == 2'd3 && r_sub == 2'd0) begin
            cur_byte = bfdc_pkg::SYNC_FF;
        end else if (i_head.nvid == 2'd3 && r_sub == 2'd1) begin
            cur_byte = bfdc_pkg::SYNC_00;
        end else if (i_head.nvid == 2'd2 && r_sub == 2'd0) begin
            cur_byte = bfdc_pkg::SYNC_FF;
        end else begin
            cur_byte = i_head.data;
        end
    end

    assign vid_final = (r_sub == (i_head.nvid - 2'd1));

    // line within field and interleaved address
    assign alc_m1        = r_alc - 11'd1;
    assign line_ext      = CMP_W'(r_line);
    assign half_ext      = CMP_W'(i_lines_per_frame[bfdc_pkg::LPF_W-1:1]);
    assign line_in_field = (line_ext >= half_ext) ? (line_ext - half_ext) : line_ext;
    assign line_match    = (r_alc != '0) && (line_in_field == CMP_W'(alc_m1));
    assign addr          = (r_second ? ADR_W'(BYTES_PER_LINE) : '0)
                         + ADR_W'(alc_m1) * ADR_W'(2 * BYTES_PER_LINE)
                         + ADR_W'(r_col);
    assign addr_ok       = addr < ADR_W'(i_frame_buffer_bytes);
    assign below_cap     = r_wp < i_frame_buffer_bytes;

    // frame end classification
    assign need     = NEED_W'(BYTES_PER_LINE) * NEED_W'(i_lines_per_frame);
    assign is_short = NEED_W'(r_wp) < need;

    // result records
    always_comb begin
        fin_res                = '0;
        fin_res.kind           = is_short ? bfdc_pkg::KIND_SHORT : bfdc_pkg::KIND_COMPLETE;
        fin_res.payload_bytes  = is_short ? '0 : r_wp;
        fin_res.frame_sequence = r_seq;
        pix_res                = '0;
        pix_res.kind           = bfdc_pkg::KIND_PIXEL;
        pix_res.write_address  = addr[bfdc_pkg::FBB_W-1:0];
        pix_res.pixel_value    = cur_byte;
        claim_res              = '0;
        claim_res.kind         = bfdc_pkg::KIND_CLAIM;
    end

    // timing code fields
    assign trc_sav = !i_head.data[bfdc_pkg::TRC_EAV_BIT];
    assign trc_act = !i_head.data[bfdc_pkg::TRC_BLANK_BIT];
    assign trc_f2  = i_head.data[bfdc_pkg::TRC_FIELD_BIT];

    // one step of the current op
    always_comb begin
        n_buf_active = r_buf_active;
        n_blanking   = r_blanking;
        n_second     = r_second;
        n_alc        = r_alc;
        n_wp         = r_wp;
        n_col        = r_col;
        n_line       = r_line;
        n_seq        = r_seq;
        n_sub        = r_sub;
        step_emit    = 1'b0;
        step_final   = 1'b0;
        step_res     = '0;
        if (step_valid) begin
            if (!i_head.is_trc) begin
                // video byte
                step_final = vid_final;
                n_sub      = vid_final ? 2'd0 : (r_sub + 2'd1);
                if (r_buf_active && !r_blanking) begin
                    if (!below_cap) begin
                        step_emit    = 1'b1;
                        step_res     = fin_res;
                        n_seq        = r_seq + 32'd1;
                        n_buf_active = 1'b0;
                    end else if (line_match && addr_ok) begin
                        step_emit = 1'b1;
                        step_res  = pix_res;
                        n_wp      = r_wp + 21'd1;
                        if (r_col == COL_W'(BYTES_PER_LINE - 1)) begin
                            n_col  = '0;
                            n_line = r_line + 1'b1;
                        end else begin
                            n_col  = r_col + 1'b1;
                        end
                    end
                end
            end else if (!r_buf_active) begin
                // claim takes its own step, then the code runs again
                step_final = 1'b1;
                if (trc_sav && trc_act && !trc_f2 && i_head.free_buf) begin
                    step_final   = 1'b0;
                    step_emit    = 1'b1;
                    step_res     = claim_res;
                    n_buf_active = 1'b1;
                    n_blanking   = 1'b0;
                    n_second     = 1'b0;
                    n_alc        = '0;
                    n_wp         = '0;
                    n_col        = '0;
                    n_line       = '0;
                end
            end else begin
                step_final = 1'b1;
                if (!trc_sav) begin
                    n_blanking = 1'b1;
                end else begin
                    n_blanking = !trc_act;
                    if (trc_act && (r_alc < bfdc_pkg::LINE_COUNT_MAX)) begin
                        n_alc = r_alc + 11'd1;
                    end
                    if (!r_second && trc_f2) begin
                        if (line_ext < half_ext) begin
                            step_emit    = 1'b1;
                            step_res     = fin_res;
                            n_seq        = r_seq + 32'd1;
                            n_buf_active = 1'b0;
                        end else begin
                            n_second = 1'b1;
                            n_alc    = '0;
                        end
                    end else if (r_second && !trc_f2) begin
                        step_emit    = 1'b1;
                        step_res     = fin_res;
                        n_seq        = r_seq + 32'd1;
                        n_buf_active = 1'b0;
                    end
                end
            end
        end
    end

    assign o_pop = step_valid && step_final;

    // hold the newest result until it is known whether another follows
    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_flush      = r_flush;
        push         = 1'b0;
        push_last    = 1'b0;
        push_res     = r_hold;
        if (slot_free && r_flush) begin
            push         = 1'b1;
            push_last    = 1'b1;
            n_hold_valid = 1'b0;
            n_flush      = 1'b0;
        end else if (step_valid) begin
            if (step_emit && r_hold_valid) begin
                push   = 1'b1;
                n_hold = step_res;
                n_flush = step_final;
            end else if (step_emit && step_final) begin
                push      = 1'b1;
                push_last = 1'b1;
                push_res  = step_res;
            end else if (step_emit) begin
                n_hold_valid = 1'b1;
                n_hold       = step_res;
            end else if (step_final && r_hold_valid) begin
                push         = 1'b1;
                push_last    = 1'b1;
                n_hold_valid = 1'b0;
            end
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_active <= 1'b0;
            r_blanking   <= 1'b0;
            r_second     <= 1'b0;
            r_alc        <= '0;
            r_wp         <= '0;
            r_col        <= '0;
            r_line       <= '0;
            r_seq        <= '0;
            r_sub        <= '0;
            r_hold_valid <= 1'b0;
            r_flush      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_buf_active <= n_buf_active;
            r_blanking   <= n_blanking;
            r_second     <= n_second;
            r_alc        <= n_alc;
            r_wp         <= n_wp;
            r_col        <= n_col;
            r_line       <= n_line;
            r_seq        <= n_seq;
            r_sub        <= n_sub;
            r_hold_valid <= n_hold_valid;
            r_flush      <= n_flush;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (push) begin
            r_out      <= push_res;
            r_out_last <= push_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_last      = r_out_last;

    // a pending flush always has a held result behind it
    a_flush_has_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_hold_valid)
        else $error("flush pending without held result");

    // column counter stays inside one line
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < COL_W'(BYTES_PER_LINE))
        else $error("column counter out of range");

    // an op is retired only when one is present
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from empty queue");

    // a result with more to follow never leaves while a flush is pending
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush && slot_free) |=> (r_out_valid && r_out_last))
        else $error("flush did not close the transfer group");

endmodule

`default_nettype wire

// File: rtl/core/bt656_field_deinterleave_capture.sv
// top level of the bt656 field deinterleave capture block
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_ready       i_data_byte, i_free_buffer
//  out       source     o_out_valid / i_out_ready     o_kind, o_write_address,
//                                                     o_pixel_value, o_payload_bytes,
//                                                     o_frame_sequence, o_last
//  cfg       sink       i_cfg_we                      i_cfg_index, i_cfg_wdata
//
//  one byte per cycle while the op queue is not full; the executor takes a step for each
//  byte that a broken preamble replays, a further step for a buffer claim, and a flush step
//  for the final transfer of a byte with several results, so the queue can fill
//  input bytes reach the results through the op queue and the output register
//  reset is synchronous: clears sync hunt, frame state, sequence count and the queue;
//  lines_per_frame returns to 480 and frame_buffer_bytes to 691200
//  o_in_ready drops only when the four-entry op queue is full; the executor stalls
//  while the output register holds a result not yet taken or a held result is being flushed
`default_nettype none

module bt656_field_deinterleave_capture #(
    parameter int BYTES_PER_LINE = 1440
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [bfdc_pkg::FBB_W-1:0]      i_cfg_wdata,
    // byte stream
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [bfdc_pkg::DATA_W-1:0]     i_data_byte,
    input  wire logic                            i_free_buffer,
    // results
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [bfdc_pkg::KIND_W-1:0]          o_kind,
    output logic [bfdc_pkg::FBB_W-1:0]           o_write_address,
    output logic [bfdc_pkg::DATA_W-1:0]          o_pixel_value,
    output logic [bfdc_pkg::FBB_W-1:0]           o_payload_bytes,
    output logic [bfdc_pkg::SEQ_W-1:0]           o_frame_sequence,
    output logic                                 o_last
);

    logic [bfdc_pkg::LPF_W-1:0]  r_lines_per_frame;
    logic [bfdc_pkg::FBB_W-1:0]  r_frame_buffer_bytes;

    logic                        q_full;
    logic                        q_push;
    bfdc_pkg::t_op               q_in;
    logic                        q_pop;
    logic                        q_valid;
    bfdc_pkg::t_op               q_head;
    bfdc_pkg::t_result           out_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines_per_frame    <= bfdc_pkg::LPF_RESET;
            r_frame_buffer_bytes <= bfdc_pkg::FBB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bfdc_pkg::CFG_LINES_PER_FRAME: begin
                    r_lines_per_frame <= i_cfg_wdata[bfdc_pkg::LPF_W-1:0];
                end
                bfdc_pkg::CFG_FRAME_BUFFER_BYTES: begin
                    r_frame_buffer_bytes <= i_cfg_wdata;
                end
            endcase
        end
    end

    // sync hunt and classification
    bfdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_free_buffer(i_free_buffer),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_op         (q_in)
    );

    // op queue
    bfdc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_op   (q_in),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_op   (q_head)
    );

    // executor
    bfdc_back #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_lines_per_frame   (r_lines_per_frame),
        .i_frame_buffer_bytes(r_frame_buffer_bytes),
        .i_head_valid        (q_valid),
        .i_head              (q_head),
        .o_pop               (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_result            (out_res),
        .o_last              (o_last)
    );

    assign o_kind           = out_res.kind;
    assign o_write_address  = out_res.write_address;
    assign o_pixel_value    = out_res.pixel_value;
    assign o_payload_bytes  = out_res.payload_bytes;
    assign o_frame_sequence = out_res.frame_sequence;

endmodule

`default_nettype wire

// File: tb/bt656_field_deinterleave_capture_tb.sv
// self-checking testbench for the bt656 field deinterleave capture block
`timescale 1ns / 1ps

module bt656_field_deinterleave_capture_tb;
    import bfdc_pkg::*;

    localparam int LINE_BYTES  = 1440;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;

    // timing reference codes used by the stimulus, protection bits clear
    localparam logic [DATA_W-1:0] TRC_SAV_F1       = 8'h80;
    localparam logic [DATA_W-1:0] TRC_EAV_F1       = 8'h90;
    localparam logic [DATA_W-1:0] TRC_EAV_BLANK_F1 = 8'hB0;
    localparam logic [DATA_W-1:0] TRC_SAV_F2       = 8'hC0;
    localparam logic [DATA_W-1:0] TRC_EAV_F2       = 8'hD0;

    typedef struct packed {
        t_result res;
        logic    last;
    } capture_result_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              free_buf;
        logic              typed;
        logic              has_result;
        capture_result_t   want;
    } plan_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [FBB_W-1:0]    i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [DATA_W-1:0]   i_data_byte;
    logic                i_free_buffer;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KIND_W-1:0]   o_kind;
    logic [FBB_W-1:0]    o_write_address;
    logic [DATA_W-1:0]   o_pixel_value;
    logic [FBB_W-1:0]    o_payload_bytes;
    logic [SEQ_W-1:0]    o_frame_sequence;
    logic                o_last;

    bt656_field_deinterleave_capture #(
        .BYTES_PER_LINE(LINE_BYTES)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_free_buffer    (i_free_buffer),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_write_address  (o_write_address),
        .o_pixel_value    (o_pixel_value),
        .o_payload_bytes  (o_payload_bytes),
        .o_frame_sequence (o_frame_sequence),
        .o_last           (o_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // deframer state mirrored by the predictor
    logic [1:0]       hunt_phase   = PH_HUNT;
    bit               frame_open   = 1'b0;
    bit               in_blank     = 1'b0;
    bit               second_field = 1'b0;
    int unsigned      line_count   = 0;
    int unsigned      wr_pos       = 0;
    logic [SEQ_W-1:0] frame_seq    = '0;
    int unsigned      lines_cfg    = LPF_RESET;
    int unsigned      capacity_cfg = FBB_RESET;

    t_result          step_results[$];
    capture_result_t  due_results[$];
    plan_row_t        directed_plan[$];

    int               mismatches = 0;
    bit               gaps_on    = 1'b1;
    bit               hold_out   = 1'b0;

    function automatic void note_result(input logic [KIND_W-1:0] kind, input int unsigned addr,
                                        input logic [DATA_W-1:0] pix,
                                        input int unsigned payload,
                                        input logic [SEQ_W-1:0] seq);
        t_result r;
        r.kind           = kind;
        r.write_address  = addr[FBB_W-1:0];
        r.pixel_value    = pix;
        r.payload_bytes  = payload[FBB_W-1:0];
        r.frame_sequence = seq;
        step_results.push_back(r);
    endfunction

    // frame ends complete or short and the buffer is released
    function automatic void close_frame();
        if (wr_pos < LINE_BYTES * lines_cfg)
            note_result(KIND_SHORT, 0, '0, 0, frame_seq);
        else
            note_result(KIND_COMPLETE, 0, '0, wr_pos, frame_seq);
        frame_seq  = frame_seq + 1'b1;
        frame_open = 1'b0;
    endfunction

    // one video byte: written to its interleaved address, or dropped
    function automatic void take_video(input logic [DATA_W-1:0] b);
        int unsigned half;
        int unsigned line;
        int unsigned col;
        int unsigned addr;
        half = lines_cfg / 2;
        if (!frame_open || in_blank)
            return;
        if (wr_pos >= capacity_cfg) begin
            close_frame();
            return;
        end
        col  = wr_pos % LINE_BYTES;
        line = wr_pos / LINE_BYTES;
        if (line >= half)
            line = line - half;
        if (line_count == 0 || line != line_count - 1)
            return;
        addr = (second_field ? LINE_BYTES : 0) + LINE_BYTES * line * 2 + col;
        if (addr >= capacity_cfg)
            return;
        note_result(KIND_PIXEL, addr, b, 0, '0);
        wr_pos = wr_pos + 1;
    endfunction

    // timing reference code after a full preamble
    function automatic void take_trc(input logic [DATA_W-1:0] code, input logic fb);
        bit is_sav;
        bit is_active;
        bit is_f2;
        is_sav    = !code[TRC_EAV_BIT];
        is_active = !code[TRC_BLANK_BIT];
        is_f2     = code[TRC_FIELD_BIT];
        if (!frame_open) begin
            if (!is_sav || !is_active || is_f2 || !fb)
                return;
            frame_open   = 1'b1;
            in_blank     = 1'b0;
            second_field = 1'b0;
            line_count   = 0;
            wr_pos       = 0;
            note_result(KIND_CLAIM, 0, '0, 0, '0);
        end
        if (!is_sav) begin
            in_blank = 1'b1;
            return;
        end
        if (is_active) begin
            in_blank = 1'b0;
            if (line_count < LINE_COUNT_MAX)
                line_count = line_count + 1;
        end else begin
            in_blank = 1'b1;
        end
        if (!second_field && is_f2) begin
            if (wr_pos / LINE_BYTES < lines_cfg / 2) begin
                close_frame();
                return;
            end
            second_field = 1'b1;
            line_count   = 0;
        end
        if (second_field && !is_f2)
            close_frame();
    endfunction

    // predicts the results of one accepted byte into step_results
    function automatic void deframe_byte(input logic [DATA_W-1:0] b, input logic fb);
        step_results.delete();
        case (hunt_phase)
            PH_HUNT: begin
                if (b == SYNC_FF)
                    hunt_phase = PH_GOT_FF;
                else
                    take_video(b);
            end
            PH_GOT_FF: begin
                if (b == SYNC_00) begin
                    hunt_phase = PH_GOT_00;
                end else begin
                    hunt_phase = PH_HUNT;
                    take_video(SYNC_FF);
                    take_video(b);
                end
            end
            PH_GOT_00: begin
                if (b == SYNC_00) begin
                    hunt_phase = PH_TRC;
                end else begin
                    hunt_phase = PH_HUNT;
                    take_video(SYNC_FF);
                    take_video(SYNC_00);
                    take_video(b);
                end
            end
            default: begin
                hunt_phase = PH_HUNT;
                take_trc(b, fb);
            end
        endcase
    endfunction

    function automatic void add_row(input logic [DATA_W-1:0] d, input logic fb,
                                    input logic typed, input logic has_result,
                                    input logic [KIND_W-1:0] kind, input int unsigned addr,
                                    input logic [DATA_W-1:0] pix, input int unsigned payload,
                                    input logic [SEQ_W-1:0] seq);
        plan_row_t row;
        row.data                     = d;
        row.free_buf                 = fb;
        row.typed                    = typed;
        row.has_result               = has_result;
        row.want.res.kind            = kind;
        row.want.res.write_address   = addr[FBB_W-1:0];
        row.want.res.pixel_value     = pix;
        row.want.res.payload_bytes   = payload[FBB_W-1:0];
        row.want.res.frame_sequence  = seq;
        row.want.last                = 1'b1;
        directed_plan.push_back(row);
    endfunction

    // offer one byte, with an occasional gap first, until its transfer
    task automatic offer_byte(input logic [DATA_W-1:0] b, input logic fb);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            i_in_valid    <= 1'b0;
            i_data_byte   <= $urandom_range(0, 255);
            i_free_buffer <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_free_buffer <= fb;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [DATA_W-1:0] b, input logic fb);
        capture_result_t ev;
        offer_byte(b, fb);
        deframe_byte(b, fb);
        foreach (step_results[k]) begin
            ev.res  = step_results[k];
            ev.last = (k == step_results.size() - 1);
            due_results.push_back(ev);
        end
    endtask

    task automatic send_trc(input logic [DATA_W-1:0] code, input logic fb);
        send_byte(SYNC_FF, $urandom_range(0, 1));
        send_byte(SYNC_00, $urandom_range(0, 1));
        send_byte(SYNC_00, $urandom_range(0, 1));
        send_byte(code, fb);
    endtask

    // active video bytes that never look like a preamble
    task automatic send_pixels(input int n);
        repeat (n) send_byte($urandom_range(1, 254), $urandom_range(0, 1));
    endtask

    // wait for the block to go idle, then write both registers
    task automatic settle_and_configure(input int unsigned lpf, input int unsigned fbb);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LINES_PER_FRAME;
        i_cfg_wdata <= lpf[FBB_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_BUFFER_BYTES;
        i_cfg_wdata <= fbb[FBB_W-1:0];
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        lines_cfg    = lpf[LPF_W-1:0];
        capacity_cfg = fbb[FBB_W-1:0];
    endtask

    // mix of sync headers, video runs, broken preambles and noise
    task automatic random_stream(input int n);
        int              sent;
        int              pick;
        int              k;
        logic [DATA_W-1:0] code;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 5))
                    0, 1: code = TRC_SAV_F1;
                    2: code = TRC_EAV_F1;
                    3: code = TRC_SAV_F2;
                    4: code = TRC_EAV_F2;
                    default: code = $urandom_range(0, 255);
                endcase
                code[3:0] = $urandom_range(0, 15);
                if ($urandom_range(0, 7) == 0)
                    code[TRC_BLANK_BIT] = 1'b1;
                send_trc(code, $urandom_range(0, 4) != 0);
                sent = sent + 4;
            end else if (pick < 75) begin
                k = $urandom_range(1, 24);
                repeat (k) send_byte($urandom_range(0, 255), $urandom_range(0, 1));
                sent = sent + k;
            end else if (pick < 90) begin
                send_byte(SYNC_FF, $urandom_range(0, 1));
                sent = sent + 2;
                if ($urandom_range(0, 1)) begin
                    send_byte(SYNC_00, $urandom_range(0, 1));
                    sent = sent + 1;
                end
                send_byte($urandom_range(1, 255), $urandom_range(0, 1));
            end else begin
                case ($urandom_range(0, 2))
                    0: send_byte(SYNC_FF, $urandom_range(0, 1));
                    1: send_byte(SYNC_00, $urandom_range(0, 1));
                    default: send_byte($urandom_range(0, 255), $urandom_range(0, 1));
                endcase
                sent = sent + 1;
            end
        end
    endtask

    // result side: random stalls, and one long hold-off on request
    initial begin : result_sink
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
                i_out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string what, input logic [SEQ_W-1:0] want,
                                        input logic [SEQ_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        capture_result_t ev;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: result expected none actual kind %0d addr %0h pixel %0h",
                         $time, o_kind, o_write_address, o_pixel_value);
                mismatches++;
            end else begin
                ev = due_results.pop_front();
                check_field("kind", ev.res.kind, o_kind);
                check_field("write_address", ev.res.write_address, o_write_address);
                check_field("pixel_value", ev.res.pixel_value, o_pixel_value);
                check_field("payload_bytes", ev.res.payload_bytes, o_payload_bytes);
                check_field("frame_sequence", ev.res.frame_sequence, o_frame_sequence);
                check_field("last", ev.last, o_last);
            end
        end
    end

    initial begin : watchdog
        #60_000_000;
        $display("[bt656_field_deinterleave_capture] ERROR");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_LINES_PER_FRAME;
        i_cfg_wdata   <= '0;
        i_in_valid    <= 1'b0;
        i_data_byte   <= '0;
        i_free_buffer <= 1'b0;

        // directed rows at reset settings: data, free, typed, has result, expected fields
        add_row(8'h00,            1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0); // no buffer yet
        add_row(SYNC_FF,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(TRC_SAV_F1,       0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0); // no free buffer
        add_row(SYNC_FF,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(TRC_SAV_F1,       1, 1, 1, KIND_CLAIM, 0, 8'h00, 0, 0);
        add_row(8'h00,            0, 1, 1, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(8'hFE,            1, 1, 1, KIND_PIXEL, 1, 8'hFE, 0, 0);
        add_row(SYNC_FF,          0, 0, 0, KIND_PIXEL, 0, 8'h00, 0, 0); // broken after ff
        add_row(8'h7F,            0, 0, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_FF,          1, 0, 0, KIND_PIXEL, 0, 8'h00, 0, 0); // broken after ff 00
        add_row(SYNC_00,          1, 0, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(8'h01,            1, 0, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_FF,          0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(TRC_EAV_BLANK_F1, 0, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(8'h55,            1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0); // blanked
        add_row(SYNC_FF,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(SYNC_00,          1, 1, 0, KIND_PIXEL, 0, 8'h00, 0, 0);
        add_row(TRC_SAV_F2,       1, 1, 1, KIND_SHORT, 0, 8'h00, 0, 0); // field 2 too early

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].typed) begin
                offer_byte(directed_plan[i].data, directed_plan[i].free_buf);
                deframe_byte(directed_plan[i].data, directed_plan[i].free_buf);
                if (directed_plan[i].has_result)
                    due_results.push_back(directed_plan[i].want);
            end else begin
                send_byte(directed_plan[i].data, directed_plan[i].free_buf);
            end
        end

        // complete two-line frame, with a long hold-off on the result side
        settle_and_configure(2, 2880);
        send_trc(TRC_SAV_F1, 1'b1);
        send_pixels(100);
        hold_out = 1'b1;
        send_pixels(1340);
        send_trc(TRC_EAV_F1, 1'b1);
        send_trc(TRC_SAV_F2, 1'b1);
        send_pixels(5);                 // line count still zero in field 2
        send_trc(TRC_EAV_F2, 1'b0);
        send_trc(TRC_SAV_F2, 1'b0);
        send_pixels(LINE_BYTES);
        send_trc(TRC_SAV_F1, 1'b0);

        // address beyond capacity, then field 2 before half a frame
        settle_and_configure(4, 2880);
        send_trc(TRC_SAV_F1, 1'b1);
        send_pixels(LINE_BYTES);
        send_trc(TRC_EAV_F1, 1'b1);
        send_trc(TRC_SAV_F1, 1'b1);
        send_pixels(8);
        send_trc(TRC_SAV_F2, 1'b1);

        // buffer full at the smallest capacity
        settle_and_configure(2, 1440);
        send_trc(TRC_SAV_F1, 1'b1);
        send_pixels(LINE_BYTES);
        send_pixels(3);

        // line count saturation at the largest settings
        settle_and_configure(1152, 1658880);
        send_trc(TRC_SAV_F1, 1'b1);
        send_pixels(4);
        repeat (2050) send_trc(TRC_SAV_F1, $urandom_range(0, 1));
        send_pixels(6);
        send_trc(TRC_SAV_F2, 1'b1);

        // random streams over several settings
        settle_and_configure(3, $urandom_range(1440, 1658880));
        random_stream(92);
        settle_and_configure(2, 1440);
        random_stream(92);
        settle_and_configure(1152, 1658880);
        random_stream(92);
        settle_and_configure($urandom_range(2, 1152), $urandom_range(1440, 1658880));
        gaps_on = 1'b0;
        random_stream(92);

        i_in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("[bt656_field_deinterleave_capture] OK");
        else
            $display("[bt656_field_deinterleave_capture] ERROR");
        $finish;
    end

endmodule
